@@ hdl/itrp_pkg.sv @@
`timescale 1ns / 1ps

package itrp_pkg;

  // Access modes held in bits 5:4 of a channel's control word.
  localparam logic [1:0] AM_LATCH = 2'd0;
  localparam logic [1:0] AM_LSB   = 2'd1;
  localparam logic [1:0] AM_MSB   = 2'd2;
  localparam logic [1:0] AM_WORD  = 2'd3;

  // Port address of the control port.
  localparam logic [1:0] CTRL_PORT = 2'd3;

  // Low six bits of a control word, and the byte that a control port read returns.
  localparam logic [5:0] LOW6_MASK = 6'h3f;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Decoded access for one channel, valid in the cycle it is applied.
  typedef struct packed {
    logic       ctrl_wr;
    logic       cnt_wr;
    logic       cnt_rd;
    logic [7:0] data;
  } chan_req_t;

  // What a channel returns for the access applied to it.
  typedef struct packed {
    logic [7:0]  rd_byte;
    logic        toggle_nxt;
    logic [15:0] reload_nxt;
  } chan_rsp_t;

endpackage

@@ hdl/itrp_channel.sv @@
`timescale 1ns / 1ps

module itrp_channel (
  input  logic                clk,
  input  logic                rst_n,
  input  itrp_pkg::chan_req_t req,
  output itrp_pkg::chan_rsp_t rsp
);
  import itrp_pkg::*;

  logic [5:0]  mode_r,   mode_nxt;
  logic        toggle_r, toggle_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [15:0] latch_r,  latch_nxt;
  logic [15:0] fake_r,   fake_nxt;
  logic [1:0]  acc_mode;
  logic [15:0] merged;
  logic [7:0]  rd_byte;

  assign acc_mode = mode_r[5:4];
  assign merged   = latch_r | {req.data, 8'h00};

  // Next state of the channel for a control write, count write or count read.
  always_comb begin
    mode_nxt   = mode_r;
    toggle_nxt = toggle_r;
    reload_nxt = reload_r;
    latch_nxt  = latch_r;
    fake_nxt   = fake_r;
    if (req.ctrl_wr) begin
      mode_nxt   = req.data[5:0] & LOW6_MASK;
      toggle_nxt = 1'b0;
      if (req.data[5:4] == AM_LATCH) begin
        // Latch command: capture the fake countdown, then step or reload it.
        latch_nxt = fake_r;
        if (fake_r == 16'd0) begin
          fake_nxt = (reload_r == 16'd0) ? 16'd0 : reload_r - 16'd1;
        end else begin
          fake_nxt = fake_r - 16'd1;
        end
      end
    end else if (req.cnt_wr) begin
      case (acc_mode)
        AM_LSB: begin
          reload_nxt = {8'h00, req.data};
          latch_nxt  = {8'h00, req.data};
        end
        AM_MSB: begin
          reload_nxt = {req.data, 8'h00};
          latch_nxt  = {req.data, 8'h00};
        end
        default: begin
          if (!toggle_r) begin
            latch_nxt  = {8'h00, req.data};
            toggle_nxt = 1'b1;
          end else begin
            latch_nxt  = merged;
            reload_nxt = merged;
            toggle_nxt = 1'b0;
          end
        end
      endcase
    end else if (req.cnt_rd) begin
      if (acc_mode != AM_LSB && acc_mode != AM_MSB) begin
        toggle_nxt = ~toggle_r;
      end
    end
  end

  // Byte returned by a count read in the current mode.
  always_comb begin
    case (acc_mode)
      AM_LSB:  rd_byte = latch_r[7:0];
      AM_MSB:  rd_byte = latch_r[15:8];
      default: rd_byte = toggle_r ? latch_r[15:8] : latch_r[7:0];
    endcase
  end

  assign rsp.rd_byte    = rd_byte;
  assign rsp.toggle_nxt = toggle_nxt;
  assign rsp.reload_nxt = reload_nxt;

  // Channel state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      toggle_r <= 1'b0;
      reload_r <= '0;
      latch_r  <= '0;
      fake_r   <= '0;
    end else begin
      mode_r   <= mode_nxt;
      toggle_r <= toggle_nxt;
      reload_r <= reload_nxt;
      latch_r  <= latch_nxt;
      fake_r   <= fake_nxt;
    end
  end

endmodule

@@ hdl/interval_timer_register_port_core.sv @@
// An accepted word is held in the input register, then in the result register,
// where its result is offered. One word per cycle while results are taken; the
// channel state is updated as a word moves from the input register to the result
// register, so the next word sees it.
// Reset (rst_n low, synchronous) clears all channel state and both valid flags.
`timescale 1ns / 1ps

module interval_timer_register_port_core #(
  parameter int CHANNEL_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [1:0]  in_port_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_byte,
  output logic        out_restart_timer,
  output logic [15:0] out_restart_count
);
  import itrp_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_kind_r;
  logic [1:0]  s1_port_r;
  logic [7:0]  s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_read_byte_r;
  logic        out_restart_timer_r;
  logic [15:0] out_restart_count_r;

  logic        advance;
  logic        in_fire;
  logic [7:0]  rd_byte;
  logic        restart;
  logic [15:0] rcount;
  logic [7:0]  chan_rd;

  chan_req_t req [CHANNEL_COUNT];
  chan_rsp_t rsp [CHANNEL_COUNT];

  // Handshake: the result register frees up when empty or taken.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Decode the registered word into per-channel accesses.
  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_chan
    assign req[i].ctrl_wr = advance && s1_kind_r == KIND_WRITE && s1_port_r == CTRL_PORT
                            && s1_data_r[7:6] == 2'(i);
    assign req[i].cnt_wr  = advance && s1_kind_r == KIND_WRITE && s1_port_r == 2'(i);
    assign req[i].cnt_rd  = advance && s1_kind_r == KIND_READ && s1_port_r == 2'(i);
    assign req[i].data    = s1_data_r;

    itrp_channel u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req[i]),
      .rsp   (rsp[i])
    );
  end

  // Select the read byte of the addressed channel.
  always_comb begin
    chan_rd = 8'h00;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (s1_port_r == 2'(i)) begin
        chan_rd = chan_rd | rsp[i].rd_byte;
      end
    end
  end

  // Result fields.
  always_comb begin
    rd_byte = 8'h00;
    restart = 1'b0;
    rcount  = 16'h0000;
    if (s1_kind_r == KIND_WRITE) begin
      if (s1_port_r == 2'd0 && !rsp[0].toggle_nxt) begin
        restart = 1'b1;
        rcount  = rsp[0].reload_nxt;
      end
    end else if (s1_port_r == CTRL_PORT) begin
      rd_byte = BYTE_MASK;
    end else begin
      rd_byte = chan_rd;
    end
  end

  // Valid flags of both stages.
  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_kind;
      s1_port_r <= in_port_address;
      s1_data_r <= in_write_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_byte_r     <= rd_byte;
      out_restart_timer_r <= restart;
      out_restart_count_r <= rcount;
    end
  end

  assign out_read_byte     = out_read_byte_r;
  assign out_restart_timer = out_restart_timer_r;
  assign out_restart_count = out_restart_count_r;

  // A restart comes only from a write, which returns a zero read byte.
  a_restart_no_read : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_restart_timer_r) |-> (out_read_byte_r == 8'h00))
    else $error("restart flagged on a result with a nonzero read byte");

  // Without a restart the count field stays zero.
  a_count_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_restart_timer_r) |-> (out_restart_count_r == 16'h0000))
    else $error("restart count nonzero without restart");

  // A word leaving the input register lands in the result register.
  a_advance_fills : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after advance");

  // The input side stalls only when both stages are full and the result is not taken.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule

@@ tb/sv/interval_timer_register_port_core_test.sv @@
`timescale 1ns / 1ps

module interval_timer_register_port_core_test;
  import itrp_pkg::*;

  localparam int NUM_CHANNELS = 3;
  localparam int RANDOM_TARGET = 1050;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  // One bus access waiting to be sent, and one reply the block owes.
  typedef struct {
    logic       kind;
    logic [1:0] port;
    logic [7:0] data;
    bit         drain_first;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        restart;
    logic [15:0] count;
  } timer_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [1:0]  in_port_address = 2'd0;
  logic [7:0]  in_write_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_restart_timer;
  logic [15:0] out_restart_count;

  interval_timer_register_port_core #(
    .CHANNEL_COUNT(NUM_CHANNELS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_port_address  (in_port_address),
    .in_write_byte    (in_write_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_restart_timer(out_restart_timer),
    .out_restart_count(out_restart_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Timer channel state as the block should hold it.
  logic [5:0]  ctl_word   [NUM_CHANNELS];
  logic        flip       [NUM_CHANNELS];
  logic [15:0] reload_cnt [NUM_CHANNELS];
  logic [15:0] latch_val  [NUM_CHANNELS];
  logic [15:0] countdown  [NUM_CHANNELS];

  bus_access_t  bus_accesses[$];
  timer_reply_t replies_due[$];

  int  total_words;
  int  words_accepted = 0;
  int  replies_checked = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  write_words = 0;
  int  read_words = 0;
  int  latch_cmds = 0;
  int  restarts_due = 0;
  int  drain_pauses = 0;
  bit  word_taken = 1'b0;

  // Sender burst and gap bookkeeping, receiver stall pattern.
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       stall_style = 0;
  int       stall_pos = 0;
  bit [7:0] stall_pattern = 8'hff;

  // Apply one accepted word to the channel state and queue the reply it owes.
  task automatic emulate_timer_access(input logic kind, input logic [1:0] port,
                                      input logic [7:0] data);
    timer_reply_t reply;
    int ch;
    logic [1:0] am;
    reply = '0;
    if (kind == KIND_WRITE) begin
      write_words++;
      if (port == CTRL_PORT) begin
        ch = int'(data[7:6]);
        if (ch < NUM_CHANNELS) begin
          ctl_word[ch] = data[5:0] & LOW6_MASK;
          flip[ch] = 1'b0;
          // A latch command captures the countdown, then steps it.
          if (data[5:4] == AM_LATCH) begin
            latch_cmds++;
            latch_val[ch] = countdown[ch];
            if (countdown[ch] == 16'd0) begin
              countdown[ch] = (reload_cnt[ch] == 16'd0) ? 16'd0 : reload_cnt[ch] - 16'd1;
            end else begin
              countdown[ch] = countdown[ch] - 16'd1;
            end
          end
        end
      end else if (int'(port) < NUM_CHANNELS) begin
        ch = int'(port);
        am = ctl_word[ch][5:4];
        case (am)
          AM_LSB: begin
            reload_cnt[ch] = {8'h00, data};
            latch_val[ch] = {8'h00, data};
          end
          AM_MSB: begin
            reload_cnt[ch] = {data, 8'h00};
            latch_val[ch] = {data, 8'h00};
          end
          default: begin
            if (!flip[ch]) begin
              latch_val[ch] = {8'h00, data};
              flip[ch] = 1'b1;
            end else begin
              latch_val[ch] = latch_val[ch] | {data, 8'h00};
              reload_cnt[ch] = latch_val[ch];
              flip[ch] = 1'b0;
            end
          end
        endcase
        // A write to channel 0 that leaves its flip-flop clear restarts the timer.
        if (port == 2'd0 && !flip[0]) begin
          reply.restart = 1'b1;
          reply.count = reload_cnt[0];
          restarts_due++;
        end
      end
    end else begin
      read_words++;
      if (port == CTRL_PORT) begin
        reply.read_byte = BYTE_MASK;
      end else if (int'(port) < NUM_CHANNELS) begin
        ch = int'(port);
        am = ctl_word[ch][5:4];
        case (am)
          AM_LSB: reply.read_byte = latch_val[ch][7:0];
          AM_MSB: reply.read_byte = latch_val[ch][15:8];
          default: begin
            reply.read_byte = flip[ch] ? latch_val[ch][15:8] : latch_val[ch][7:0];
            flip[ch] = ~flip[ch];
          end
        endcase
      end
    end
    replies_due.push_back(reply);
  endtask

  function automatic void queue_access(logic kind, logic [1:0] port, logic [7:0] data,
                                       bit drain_first = 1'b0);
    bus_access_t acc;
    acc.kind = kind;
    acc.port = port;
    acc.data = data;
    // Now and then the sender waits for every reply before the next word.
    acc.drain_first = drain_first || ($urandom_range(0, 249) == 0);
    bus_accesses.push_back(acc);
  endfunction

  // Data bytes lean toward the extremes now and then.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // Channel for a control word; a select with no channel shows up now and then.
  function automatic logic [1:0] pick_select();
    if ($urandom_range(0, 11) == 0) return 2'd3;
    return 2'($urandom_range(0, NUM_CHANNELS - 1));
  endfunction

  // Driver: present the next word once the current one has been taken.
  always @(negedge clk) begin : drive_words
    bus_access_t nxt;
    if (rst_n && (!in_valid || word_taken)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (bus_accesses.size() > 0 &&
                   !(bus_accesses[0].drain_first && replies_due.size() != 0)) begin
        nxt = bus_accesses.pop_front();
        if (nxt.drain_first) drain_pauses++;
        in_valid <= 1'b1;
        in_kind <= nxt.kind;
        in_port_address <= nxt.port;
        in_write_byte <= nxt.data;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap_left = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: phases of always ready, random stalls and a repeating pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
      stall_pattern = 8'($urandom) | 8'h01;
    end
    stall_left = stall_left - 1;
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: begin
        out_ready <= stall_pattern[stall_pos];
        stall_pos = (stall_pos + 1) % 8;
      end
      default: out_ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // Monitor: check each reply, then record the word taken at this edge.
  always @(posedge clk) begin : watch_ports
    timer_reply_t want;
    if (rst_n) begin
      word_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected reply: read_byte %02h restart %0b count %04h",
                     out_read_byte, out_restart_timer, out_restart_count);
          end
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          if (out_read_byte !== want.read_byte || out_restart_timer !== want.restart ||
              out_restart_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("reply %0d differs: read_byte exp %02h got %02h, ",
                     replies_checked, want.read_byte, out_read_byte);
              $display("restart exp %0b got %0b, count exp %04h got %04h",
                       want.restart, out_restart_timer, want.count, out_restart_count);
            end
          end
        end
      end
      if (word_taken) begin
        emulate_timer_access(in_kind, in_port_address, in_write_byte);
        words_accepted++;
      end
      // Watchdog on cycles where neither side moves a word.
      if (word_taken || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("interval_timer_register_port_core_test: done, errors");
        $finish;
      end
    end else begin
      word_taken = 1'b0;
    end
  end

  initial begin
    int pick;
    int n;
    logic [1:0] ch;
    logic [1:0] am;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ctl_word[i] = '0;
      flip[i] = 1'b0;
      reload_cnt[i] = '0;
      latch_val[i] = '0;
      countdown[i] = '0;
    end

    // Directed words: reset reads, ignored selects, each access mode, latches
    // before and after a load, and restarts with the extreme counts.
    queue_access(KIND_READ, CTRL_PORT, 8'h5a);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_READ, 2'd0, 8'hff);
    queue_access(KIND_WRITE, CTRL_PORT, 8'hff);
    queue_access(KIND_WRITE, CTRL_PORT, 8'hc0);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h40);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h3e);
    queue_access(KIND_WRITE, 2'd0, 8'hff);
    queue_access(KIND_WRITE, 2'd0, 8'hff);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h00);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h0f);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_READ, 2'd0, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h51);
    queue_access(KIND_WRITE, 2'd1, 8'h5a);
    queue_access(KIND_READ, 2'd1, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'ha4);
    queue_access(KIND_WRITE, 2'd2, 8'ha5, 1'b1);
    queue_access(KIND_READ, 2'd2, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h10);
    queue_access(KIND_WRITE, 2'd0, 8'h00);
    queue_access(KIND_WRITE, CTRL_PORT, 8'h20);
    queue_access(KIND_WRITE, 2'd0, 8'h80);

    // Random part: mostly well-formed program, load, latch and read sequences.
    while (bus_accesses.size() < RANDOM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_access(1'($urandom), 2'($urandom), pick_byte());
      end else if (pick <= 5) begin
        ch = pick_select();
        am = 2'($urandom_range(1, 3));
        queue_access(KIND_WRITE, CTRL_PORT, {ch, am, 4'($urandom)});
        n = (am == AM_WORD && $urandom_range(0, 5) != 0) ? 2 : $urandom_range(0, 2);
        repeat (n) queue_access(KIND_WRITE, ch, pick_byte());
        n = $urandom_range(0, 3);
        repeat (n) queue_access(KIND_READ, ch, pick_byte());
      end else if (pick <= 7) begin
        ch = pick_select();
        queue_access(KIND_WRITE, CTRL_PORT, {ch, AM_LATCH, 4'($urandom)});
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 2;
        repeat (n) queue_access(KIND_READ, ch, pick_byte());
      end else if (pick == 8) begin
        n = $urandom_range(1, 5);
        repeat (n) queue_access(KIND_READ, 2'($urandom), pick_byte());
      end else begin
        queue_access(KIND_WRITE, CTRL_PORT, {2'd0, AM_WORD, 4'($urandom)});
        n = $urandom_range(1, 3);
        repeat (2 * n) queue_access(KIND_WRITE, 2'd0, pick_byte());
      end
    end
    total_words = bus_accesses.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every word to go in and every reply to come out, then settle.
    while (words_accepted < total_words) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d writes, %0d reads), %0d latch commands, %0d restarts",
             words_accepted, write_words, read_words, latch_cmds, restarts_due);
    $display("checked %0d replies after %0d drain pauses, %0d mismatches",
             replies_checked, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("interval_timer_register_port_core_test: done, clean");
    end else begin
      $display("interval_timer_register_port_core_test: done, errors");
    end
    $finish;
  end

endmodule
